// ===== hdl/lirg_pkg.sv =====
// ----------------------------------------------------------------------------
// Linear interpolation resampler package
// Shared widths, register codes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package lirg_pkg;

  localparam int SmpW      = 16;
  localparam int LenW      = 16;
  localparam int StepW     = 21;
  localparam int GainW     = 16;
  localparam int GainFracW = 12;
  localparam int MaxOut    = 64;
  localparam int CntW      = 7;
  localparam int AddrW     = 3;
  localparam int DataW     = 32;

  localparam logic [StepW-1:0] StepReset = StepW'(65536);
  localparam logic [GainW-1:0] GainReset = GainW'(4096);

  typedef enum logic {
    REG_STEP = 1'b0,
    REG_GAIN = 1'b1
  } lirg_reg_e;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_MUL1  = 6'b000100,
    S_MUL2  = 6'b001000,
    S_PUSH  = 6'b010000,
    S_FINAL = 6'b100000
  } lirg_state_e;

endpackage

`default_nettype wire

// ===== hdl/linear_interp_resampler_with_gain.sv =====
// Each result word passes twice through the shared multiplier, first to
// interpolate and then to apply the gain. A word is held back until the next
// word of its item or the end of the item pushes it out; output stalls hold
// the flow. A new input sample is taken only in the idle state, once the
// last item is done. Reset clears the state and loads step 1.0 and gain 1.0;
// a sample can be accepted as soon as reset ends.
// ----------------------------------------------------------------------------
// Linear interpolation resampler with gain
// Resamples a stream of sample blocks at a programmable step by linear
// interpolation, scales each word by a linear gain and saturates it.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_interp_resampler_with_gain #(
  parameter int MAX_BLOCK = 65535,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [lirg_pkg::AddrW-1:0]     paddr,
  input  wire logic [lirg_pkg::DataW-1:0]     pwdata,
  output logic      [lirg_pkg::DataW-1:0]     prdata,
  output logic                                pready,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic signed [lirg_pkg::SmpW-1:0] sample_i,
  input  wire logic [lirg_pkg::LenW-1:0]      block_length_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic signed [lirg_pkg::SmpW-1:0]    out_sample_o,
  output logic                                run_last_o,
  output logic                                block_end_o
);
  import lirg_pkg::*;

  localparam int PosW  = LenW + FRAC_BITS + 2;
  localparam int OpaW  = FRAC_BITS + 19;
  localparam int OpbW  = ((FRAC_BITS > GainW) ? FRAC_BITS : GainW) + 1;
  localparam int ProdW = OpaW + OpbW;
  localparam int RndSh = FRAC_BITS + GainFracW;
  localparam logic [StepW-1:0] MinStep = StepW'(2 ** (FRAC_BITS - 5));
  localparam logic [31:0] MaxBlk = 32'(MAX_BLOCK);
  localparam logic signed [ProdW-1:0] RndHalf = ProdW'(1) <<< (RndSh - 1);
  localparam logic signed [ProdW-1:0] SatHi = ProdW'(32'sd32767);
  localparam logic signed [ProdW-1:0] SatLo = ProdW'(-32'sd32768);

  lirg_state_e state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic [GainW-1:0] gain_q, gain_d;
  logic signed [SmpW-1:0] prev_q, prev_d;
  logic [LenW-1:0] idx_q, idx_d;
  logic [PosW-1:0] np_q, np_d;
  logic [CntW-1:0] k_q, k_d;
  logic hold_v_q, hold_v_d;
  logic out_valid_q, out_valid_d;

  logic signed [SmpW-1:0] cur_q, cur_d;
  logic [PosW-1:0] limit_q, limit_d;
  logic [PosW-1:0] here_q, here_d;
  logic [PosW-1:0] base_q, base_d;
  logic [StepW-1:0] st_q, st_d;
  logic last_q, last_d;
  logic nz_q, nz_d;
  logic signed [SmpW-1:0] a_q, a_d;
  logic signed [SmpW:0] diff_q, diff_d;
  logic [FRAC_BITS-1:0] frac_q, frac_d;
  logic signed [ProdW-1:0] prod_q, prod_d;
  logic signed [SmpW-1:0] hold_q, hold_d;
  logic signed [SmpW-1:0] out_sample_q, out_sample_d;
  logic run_last_q, run_last_d;
  logic block_end_q, block_end_d;

  logic cfg_wr;
  logic [LenW-1:0] len_nz, len_eff;
  logic [PosW-1:0] np_next, np_off;
  logic fits, room, interp, flat, slot_free;
  logic signed [OpaW-1:0] opa, v_sum;
  logic signed [OpbW-1:0] opb;
  logic signed [ProdW-1:0] mul_res, rsum, rshift;
  logic signed [SmpW-1:0] rnd_val;

  assign pready     = 1'b1;
  assign cfg_wr     = psel & penable & pwrite & pready;
  assign in_stall_o = (state_q != S_IDLE);
  assign slot_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    unique case (lirg_reg_e'(paddr[2]))
      REG_STEP: prdata = DataW'(step_q);
      REG_GAIN: prdata = DataW'(gain_q);
      default:  prdata = '0;
    endcase
  end

  always_comb begin
    len_nz  = (block_length_i == '0) ? LenW'(1) : block_length_i;
    len_eff = (32'(len_nz) > MaxBlk) ? MaxBlk[LenW-1:0] : len_nz;
  end

  always_comb begin
    np_next = np_q + PosW'(st_q);
    np_off  = np_q - base_q;
    fits    = (np_next <= limit_q);
    room    = !k_q[CntW-1];
    interp  = nz_q && (np_q < here_q) && fits && room;
    flat    = last_q && fits && room;
  end

  always_comb begin
    v_sum = (OpaW'(a_q) <<< FRAC_BITS) + $signed(prod_q[OpaW-1:0]);
    if (state_q == S_MUL2) begin
      opa = v_sum;
      opb = $signed(OpbW'(gain_q));
    end else begin
      opa = OpaW'(diff_q);
      opb = $signed(OpbW'(frac_q));
    end
    mul_res = ProdW'(opa) * ProdW'(opb);
  end

  always_comb begin
    rsum   = prod_q + RndHalf;
    rshift = rsum >>> RndSh;
    if (rshift > SatHi) begin
      rnd_val = SatHi[SmpW-1:0];
    end else if (rshift < SatLo) begin
      rnd_val = SatLo[SmpW-1:0];
    end else begin
      rnd_val = rshift[SmpW-1:0];
    end
  end

  always_comb begin
    state_d      = state_q;
    step_d       = step_q;
    gain_d       = gain_q;
    prev_d       = prev_q;
    idx_d        = idx_q;
    np_d         = np_q;
    k_d          = k_q;
    hold_v_d     = hold_v_q;
    out_valid_d  = out_valid_q && out_stall_i;
    cur_d        = cur_q;
    limit_d      = limit_q;
    here_d       = here_q;
    base_d       = base_q;
    st_d         = st_q;
    last_d       = last_q;
    nz_d         = nz_q;
    a_d          = a_q;
    diff_d       = diff_q;
    frac_d       = frac_q;
    prod_d       = prod_q;
    hold_d       = hold_q;
    out_sample_d = out_sample_q;
    run_last_d   = run_last_q;
    block_end_d  = block_end_q;

    if (cfg_wr) begin
      unique case (lirg_reg_e'(paddr[2]))
        REG_STEP: step_d = pwdata[StepW-1:0];
        REG_GAIN: gain_d = pwdata[GainW-1:0];
        default:  ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cur_d   = sample_i;
          limit_d = PosW'(len_eff) << FRAC_BITS;
          here_d  = PosW'(idx_q) << FRAC_BITS;
          base_d  = (PosW'(idx_q) << FRAC_BITS) - (PosW'(1) << FRAC_BITS);
          st_d    = (step_q < MinStep) ? MinStep : step_q;
          last_d  = ({1'b0, idx_q} + (LenW + 1)'(1)) >= {1'b0, len_eff};
          nz_d    = (idx_q != '0);
          k_d     = '0;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (interp) begin
          a_d     = prev_q;
          diff_d  = (SmpW + 1)'(cur_q) - (SmpW + 1)'(prev_q);
          frac_d  = (np_q >= base_q) ? np_off[FRAC_BITS-1:0] : '0;
          np_d    = np_next;
          k_d     = k_q + CntW'(1);
          state_d = S_MUL1;
        end else if (flat) begin
          a_d     = cur_q;
          diff_d  = '0;
          frac_d  = '0;
          np_d    = np_next;
          k_d     = k_q + CntW'(1);
          state_d = S_MUL1;
        end else begin
          prev_d = cur_q;
          if (last_q) begin
            idx_d = '0;
            np_d  = '0;
          end else begin
            idx_d = idx_q + LenW'(1);
          end
          state_d = hold_v_q ? S_FINAL : S_IDLE;
        end
      end
      S_MUL1: begin
        prod_d  = mul_res;
        state_d = S_MUL2;
      end
      S_MUL2: begin
        prod_d  = mul_res;
        state_d = S_PUSH;
      end
      S_PUSH: begin
        if (!hold_v_q || slot_free) begin
          if (hold_v_q) begin
            out_sample_d = hold_q;
            run_last_d   = 1'b0;
            block_end_d  = 1'b0;
            out_valid_d  = 1'b1;
          end
          hold_d   = rnd_val;
          hold_v_d = 1'b1;
          state_d  = S_CHECK;
        end
      end
      S_FINAL: begin
        if (slot_free) begin
          out_sample_d = hold_q;
          run_last_d   = 1'b1;
          block_end_d  = last_q;
          out_valid_d  = 1'b1;
          hold_v_d     = 1'b0;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= StepReset;
      gain_q      <= GainReset;
      prev_q      <= '0;
      idx_q       <= '0;
      np_q        <= '0;
      k_q         <= '0;
      hold_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      gain_q      <= gain_d;
      prev_q      <= prev_d;
      idx_q       <= idx_d;
      np_q        <= np_d;
      k_q         <= k_d;
      hold_v_q    <= hold_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q        <= cur_d;
    limit_q      <= limit_d;
    here_q       <= here_d;
    base_q       <= base_d;
    st_q         <= st_d;
    last_q       <= last_d;
    nz_q         <= nz_d;
    a_q          <= a_d;
    diff_q       <= diff_d;
    frac_q       <= frac_d;
    prod_q       <= prod_d;
    hold_q       <= hold_d;
    out_sample_q <= out_sample_d;
    run_last_q   <= run_last_d;
    block_end_q  <= block_end_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_sample_q;
  assign run_last_o   = run_last_q;
  assign block_end_o  = block_end_q;

endmodule

`default_nettype wire

// ===== tb/tb_linear_interp_resampler_with_gain.sv =====
// ----------------------------------------------------------------------------
// Linear interpolation resampler with gain testbench
// Drives sample blocks and register writes into the resampler and checks
// every output word against a cycle-free model of the resampler, or against
// table values for fixed directed rows. The directed table runs first, then
// random blocks under several step and gain settings and stalls on both ends.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_linear_interp_resampler_with_gain;

  import lirg_pkg::*;

  localparam int FracBits      = 16;
  localparam int MaxBlock      = 65535;
  localparam int AddrWidth     = lirg_pkg::AddrW;
  localparam longint Unit      = longint'(1) << FracBits;
  localparam longint MinStep   = longint'(1) << (FracBits - 5);
  localparam int ScaleShift    = FracBits + GainFracW;
  localparam int DrainCycles   = 300;
  localparam int ItemsPerPhase = 56;
  localparam int MinWords      = 40;
  localparam int NumRows       = 30;
  localparam int NumPhases     = 8;
  localparam longint TimeLimit = 64'd32_000_000;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_e;

  typedef struct {
    row_kind_e          kind;
    lirg_reg_e          reg_sel;
    logic [31:0]        value;
    logic signed [15:0] smp;
    logic [15:0]        len;
    bit                 fixed;
    logic signed [15:0] exp_smp;
    bit                 exp_last;
    bit                 exp_end;
  } stim_row_t;

  typedef struct {
    logic signed [SmpW-1:0] smp;
    bit                     run_last;
    bit                     block_end;
  } out_word_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [AddrW-1:0]     paddr;
  logic [DataW-1:0]     pwdata;
  logic [DataW-1:0]     prdata;
  logic                 pready;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic signed [SmpW-1:0] sample_i;
  logic [LenW-1:0]      block_length_i;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic signed [SmpW-1:0] out_sample_o;
  logic                 run_last_o;
  logic                 block_end_o;

  logic [StepW-1:0]     cfg_step;
  logic [GainW-1:0]     cfg_gain;
  logic signed [SmpW-1:0] prev_smp;
  logic [LenW-1:0]      smp_idx;
  longint unsigned      next_pos;

  out_word_t            expected_words[$];
  int unsigned          err_cnt;
  int unsigned          items_sent;
  int unsigned          words_predicted;
  int unsigned          snd_idle_pct;
  int unsigned          rcv_stall_pct;

  stim_row_t            dir_rows [NumRows];
  logic [StepW-1:0]     plan_step [NumPhases];
  logic [GainW-1:0]     plan_gain [NumPhases];
  int unsigned          idle_snd [4];
  int unsigned          idle_rcv [4];

  linear_interp_resampler_with_gain uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_i       (sample_i),
    .block_length_i (block_length_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_sample_o   (out_sample_o),
    .run_last_o     (run_last_o),
    .block_end_o    (block_end_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic logic signed [SmpW-1:0] scale_sample(longint a, longint b, longint frac);
    longint v;
    longint r;
    v = a * Unit + (b - a) * frac;
    r = v * longint'(cfg_gain) + (longint'(1) << (ScaleShift - 1));
    r = r >>> ScaleShift;
    if (r > 32767) begin
      r = 32767;
    end else if (r < -32768) begin
      r = -32768;
    end
    return r[SmpW-1:0];
  endfunction

  function automatic void resample_item(logic signed [SmpW-1:0] smp, logic [LenW-1:0] len_in,
                                        bit push);
    longint unsigned len;
    longint unsigned st;
    longint unsigned limit;
    longint unsigned here;
    longint unsigned base;
    longint          frac;
    bit              last;
    out_word_t       w;
    out_word_t       words[$];
    len = (len_in == 0) ? 1 : len_in;
    if (len > MaxBlock) begin
      len = MaxBlock;
    end
    st = (cfg_step < MinStep) ? MinStep : cfg_step;
    last = (longint'(smp_idx) + 1 >= len);
    limit = len << FracBits;
    here = longint'(smp_idx) << FracBits;
    w.run_last = 1'b0;
    w.block_end = 1'b0;
    if (smp_idx >= 1) begin
      base = here - Unit;
      while (words.size() < MaxOut && next_pos < here && next_pos + st <= limit) begin
        frac = (next_pos >= base) ? longint'(next_pos - base) : 0;
        w.smp = scale_sample(prev_smp, smp, frac);
        words.push_back(w);
        next_pos += st;
      end
    end
    if (last) begin
      while (words.size() < MaxOut && next_pos + st <= limit) begin
        w.smp = scale_sample(smp, smp, 0);
        words.push_back(w);
        next_pos += st;
      end
    end
    if (words.size() > 0) begin
      words[words.size() - 1].run_last = 1'b1;
      words[words.size() - 1].block_end = last;
    end
    words_predicted += words.size();
    if (push) begin
      foreach (words[i]) expected_words.push_back(words[i]);
    end
    prev_smp = smp;
    if (last) begin
      smp_idx = '0;
      next_pos = 0;
    end else begin
      smp_idx = smp_idx + 1'b1;
    end
  endfunction

  function automatic logic signed [SmpW-1:0] rand_sample();
    if ($urandom_range(9) == 0) begin
      return ($urandom_range(1) == 1) ? 16'sh7fff : 16'sh8000;
    end
    return 16'($urandom);
  endfunction

  task automatic send_item(input logic signed [SmpW-1:0] smp, input logic [LenW-1:0] len,
                           input bit push);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    sample_i = smp;
    block_length_i = len;
    resample_item(smp, len, push);
    items_sent++;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (expected_words.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic apb_write(input lirg_reg_e sel, input logic [31:0] val);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = AddrWidth'(4 * int'(sel));
    pwdata = val;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    if (sel == REG_STEP) begin
      cfg_step = val[StepW-1:0];
    end else begin
      cfg_gain = val[GainW-1:0];
    end
  endtask

  task automatic send_random_block();
    int unsigned sel;
    int unsigned blk_len;
    int unsigned n_items;
    logic [LenW-1:0] odd_len;
    sel = $urandom_range(99);
    if (sel < 12) begin
      odd_len = ($urandom_range(7) == 0) ? '0 : LenW'($urandom_range(0, 65535));
      send_item(rand_sample(), odd_len, 1'b1);
    end else begin
      sel = $urandom_range(99);
      if (sel < 60) begin
        blk_len = $urandom_range(1, 8);
      end else if (sel < 88) begin
        blk_len = $urandom_range(9, 40);
      end else begin
        blk_len = $urandom_range(41, 120);
      end
      n_items = ($urandom_range(9) == 0) ? $urandom_range(1, blk_len) : blk_len;
      for (int j = 0; j < n_items; j++) begin
        send_item(rand_sample(), LenW'(blk_len), 1'b1);
      end
    end
  endtask

  always @(negedge clk_i) begin
    out_stall_i = ($urandom_range(99) < rcv_stall_pct);
  end

  always @(posedge clk_i) begin : out_check
    out_word_t exp_w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_words.size() == 0) begin
        $error("word with no expectation: out_sample %0d", out_sample_o);
        err_cnt++;
      end else begin
        exp_w = expected_words.pop_front();
        if (out_sample_o !== exp_w.smp) begin
          $error("out_sample expected %0d, got %0d", exp_w.smp, out_sample_o);
          err_cnt++;
        end
        if (run_last_o !== exp_w.run_last) begin
          $error("run_last expected %0d, got %0d", exp_w.run_last, run_last_o);
          err_cnt++;
        end
        if (block_end_o !== exp_w.block_end) begin
          $error("block_end expected %0d, got %0d", exp_w.block_end, block_end_o);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    #(TimeLimit);
    $display("linear_interp_resampler_with_gain test failed");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    sample_i = '0;
    block_length_i = '0;
    err_cnt = 0;
    items_sent = 0;
    words_predicted = 0;
    snd_idle_pct = 0;
    rcv_stall_pct = 0;
    cfg_step = StepReset;
    cfg_gain = GainReset;
    prev_smp = '0;
    smp_idx = '0;
    next_pos = 0;

    // Directed rows: interpolation at step 1.0, gain extremes and rounding,
    // then a long step that holds outputs back, the minimum step that makes
    // them burst past the per-item cap, a shrunken length and an empty block.
    dir_rows = '{
      '{ROW_ITEM, REG_STEP, 0,       32767,  1,   1, 32767,  1, 1},
      '{ROW_ITEM, REG_STEP, 0,       -32768, 0,   1, -32768, 1, 1},
      '{ROW_ITEM, REG_STEP, 0,       100,    2,   0, 0,      0, 0},
      '{ROW_ITEM, REG_STEP, 0,       300,    2,   0, 0,      0, 0},
      '{ROW_ITEM, REG_STEP, 0,       -32768, 3,   0, 0,      0, 0},
      '{ROW_ITEM, REG_STEP, 0,       32767,  3,   0, 0,      0, 0},
      '{ROW_ITEM, REG_STEP, 0,       0,      3,   0, 0,      0, 0},
      '{ROW_CFG,  REG_GAIN, 65535,   0,      0,   0, 0,      0, 0},
      '{ROW_ITEM, REG_STEP, 0,       32767,  1,   1, 32767,  1, 1},
      '{ROW_ITEM, REG_STEP, 0,       -32768, 1,   1, -32768, 1, 1},
      '{ROW_CFG,  REG_GAIN, 0,       0,      0,   0, 0,      0, 0},
      '{ROW_ITEM, REG_STEP, 0,       12345,  1,   1, 0,      1, 1},
      '{ROW_CFG,  REG_GAIN, 2048,    0,      0,   0, 0,      0, 0},
      '{ROW_ITEM, REG_STEP, 0,       1,      1,   1, 1,      1, 1},
      '{ROW_ITEM, REG_STEP, 0,       -1,     1,   1, 0,      1, 1},
      '{ROW_CFG,  REG_GAIN, 4096,    0,      0,   0, 0,      0, 0},
      '{ROW_CFG,  REG_STEP, 2097151, 0,      0,   0, 0,      0, 0},
      '{ROW_ITEM, REG_STEP, 0,       500,    2,   0, 0,      0, 0},
      '{ROW_ITEM, REG_STEP, 0,       -500,   3,   0, 0,      0, 0},
      '{ROW_ITEM, REG_STEP, 0,       700,    4,   0, 0,      0, 0},
      '{ROW_ITEM, REG_STEP, 0,       -700,   5,   0, 0,      0, 0},
      '{ROW_ITEM, REG_STEP, 0,       900,    6,   0, 0,      0, 0},
      '{ROW_ITEM, REG_STEP, 0,       -900,   7,   0, 0,      0, 0},
      '{ROW_CFG,  REG_STEP, 0,       0,      0,   0, 0,      0, 0},
      '{ROW_ITEM, REG_STEP, 0,       20000,  100, 0, 0,      0, 0},
      '{ROW_ITEM, REG_STEP, 0,       -20000, 8,   0, 0,      0, 0},
      '{ROW_CFG,  REG_STEP, 1048576, 0,      0,   0, 0,      0, 0},
      '{ROW_ITEM, REG_STEP, 0,       1,      3,   0, 0,      0, 0},
      '{ROW_ITEM, REG_STEP, 0,       2,      3,   0, 0,      0, 0},
      '{ROW_ITEM, REG_STEP, 0,       3,      3,   0, 0,      0, 0}
    };

    plan_step = '{21'd2048, 21'd65536, 21'd0, 21'd262144,
                  21'd32768, 21'd65536, 21'd131072, 21'd2048};
    plan_gain = '{16'd65535, 16'd4096, 16'd0, 16'd4096,
                  16'd12000, 16'd4096, 16'd2048, 16'd4096};
    plan_step[5] = StepW'($urandom_range(2048, 196608));
    plan_step[7] = StepW'($urandom_range(2048, 65536));
    plan_gain[3] = GainW'($urandom_range(0, 65535));
    plan_gain[5] = GainW'($urandom_range(0, 65535));
    idle_snd = '{0, 81, 0, 28};
    idle_rcv = '{0, 0, 81, 28};

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        wait_idle();
        apb_write(dir_rows[r].reg_sel, dir_rows[r].value);
      end else if (dir_rows[r].fixed) begin
        expected_words.push_back('{dir_rows[r].exp_smp, dir_rows[r].exp_last,
                                   dir_rows[r].exp_end});
        send_item(dir_rows[r].smp, dir_rows[r].len, 1'b0);
      end else begin
        send_item(dir_rows[r].smp, dir_rows[r].len, 1'b1);
      end
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      wait_idle();
      snd_idle_pct = idle_snd[ph / 2];
      rcv_stall_pct = idle_rcv[ph / 2];
      apb_write(REG_STEP, 32'(plan_step[ph]));
      apb_write(REG_GAIN, 32'(plan_gain[ph]));
      items_sent = 0;
      words_predicted = 0;
      while (items_sent < ItemsPerPhase || words_predicted < MinWords) begin
        send_random_block();
      end
    end

    wait_idle();
    if (err_cnt == 0) begin
      $display("linear_interp_resampler_with_gain test passed");
    end else begin
      $display("linear_interp_resampler_with_gain test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/lirg_pkg.sv
hdl/linear_interp_resampler_with_gain.sv
tb/tb_linear_interp_resampler_with_gain.sv
